@@ hdl/lfxd_pkg.sv @@
// lfxd_pkg: beat types, status and operation codes for the length framed
// xor deframer; no dependencies
`default_nettype none

package lfxd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int HdrCntW      = 3;

  localparam logic [HdrCntW-1:0] HDR_FIRST   = HdrCntW'(0);
  localparam logic [HdrCntW-1:0] HDR_FINAL   = HdrCntW'(HEADER_BYTES - 1);
  localparam logic [HdrCntW-1:0] HDR_PAYLOAD = HdrCntW'(HEADER_BYTES);

  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [1:0] STATUS_PAYLOAD   = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
    logic [5:0] pool_index;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        last;
    logic [31:0] frame_length;
  } out_beat_t;

  // key pool access, addresses sized for the largest pool
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr;
  } pool_req_t;

endpackage

`default_nettype wire

@@ hdl/lfxd_resid.sv @@
// lfxd_resid: one byte step of a running residue, (r*256 + b) mod MODULUS
// built from two constant tables and one compare and subtract; no package
`default_nettype none

module lfxd_resid #(
  parameter int MODULUS = 31,
  parameter int RW      = 5
) (
  input  logic [RW-1:0] resid_i,
  input  logic [7:0]    byte_i,
  output logic [RW-1:0] resid_o
);

  localparam logic [RW:0] ModW = (RW+1)'(MODULUS);

  logic [RW-1:0] tab_hi [2**RW];
  logic [RW-1:0] tab_lo [256];
  logic [RW:0]   sum;

  for (genvar i = 0; i < 2**RW; i++) begin : g_hi
    assign tab_hi[i] = RW'((i * 256) % MODULUS);
  end

  for (genvar j = 0; j < 256; j++) begin : g_lo
    assign tab_lo[j] = RW'(j % MODULUS);
  end

  // both terms below the modulus, so one correction is enough
  assign sum     = {1'b0, tab_hi[resid_i]} + {1'b0, tab_lo[byte_i]};
  assign resid_o = (sum >= ModW) ? RW'(sum - ModW) : sum[RW-1:0];

endmodule

`default_nettype wire

@@ hdl/lfxd_pool.sv @@
// lfxd_pool: key pool memory, one write port and one registered read port
// depends on lfxd_pkg for the access struct
`default_nettype none

module lfxd_pool
  import lfxd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic      clk_i,
  input  pool_req_t req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hdl/length_framed_xor_deframer.sv @@
// length_framed_xor_deframer: top level, frame parsing, key sequencing and
// output register; depends on lfxd_pkg, lfxd_resid and lfxd_pool
//
// usage
//   in channel  : in_valid_i / in_stall_o / in_beat_i, one beat per cycle
//                 unless stalled, either a link byte or a key pool load
//   out channel : out_valid_o / out_stall_i / out_beat_o, at most one beat
//                 per input beat
//   cfg channel : cfg_valid_i / cfg_ready_o / cfg_data_i writes the largest
//                 accepted frame length; always ready
//   each frame is a 4-byte big-endian length and then the payload; every
//   payload byte leaves xored with a repeating key taken from the pool
//   throughput: one input beat per cycle while the input is not stalled
//   output register: a result is registered and appears in the cycle after
//     its input beat; the pool read port registers the key byte alongside it
//   the length residues (key length, pool start) are built byte by byte as
//   the header arrives, so the first payload byte may follow the header
//   directly
//   when the receiver stalls, the result holds in the output register and
//   the input side stalls only while that register is full and stalled
//   reset: header hunt from the first byte, limit 65536, key length one;
//   the pool is not cleared and must be loaded before use
`default_nettype none

module length_framed_xor_deframer
  import lfxd_pkg::*;
#(
  parameter int POOL_DEPTH = 64,
  parameter int KEY_SPAN   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int AW     = $clog2(POOL_DEPTH);
  localparam int KeyMod = KEY_SPAN - 1;
  localparam int KW     = (KeyMod > 1) ? $clog2(KeyMod) : 1;
  localparam logic [AW-1:0] AddrTop = AW'(POOL_DEPTH - 1);

  // handshake
  logic in_acc;
  logic is_stream;
  logic is_load;

  // framing state
  logic [HdrCntW-1:0] hb_q, hb_d;
  logic [23:0]        shift_q, shift_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        remain_q, remain_d;
  logic [31:0]        max_len_q;

  // running residues of the header
  logic [KW-1:0] res_k_q, res_k_d, res_k_in, res_k_next;
  logic [AW-1:0] res_p_q, res_p_d, res_p_in, res_p_next;

  // key sequencing: phase runs 0..klast, addr tracks (start + phase) mod depth
  logic [KW-1:0] klast_q, klast_d;
  logic [KW-1:0] phase_q, phase_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          wrap;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        emit;
  logic [1:0]  emit_status;
  logic        emit_last;
  logic [7:0]  byte_q;
  logic        xor_en_q;
  logic [1:0]  status_q;
  logic        last_q;
  logic [31:0] flen_q;

  // pool
  pool_req_t  pool_req;
  logic [7:0] pool_rd;
  logic [7:0] idx_wide;
  logic [31:0] hdr_len;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_stream   = in_acc && (in_beat_i.operation == OP_STREAM);
  assign is_load     = in_acc && (in_beat_i.operation == OP_LOAD);
  assign cfg_ready_o = 1'b1;

  assign hdr_len  = {shift_q, in_beat_i.in_byte};
  assign idx_wide = {2'b00, in_beat_i.pool_index};

  // residues start over on the first header byte
  assign res_k_in = (hb_q == HDR_FIRST) ? '0 : res_k_q;
  assign res_p_in = (hb_q == HDR_FIRST) ? '0 : res_p_q;

  lfxd_resid #(
    .MODULUS (KeyMod),
    .RW      (KW)
  ) u_resid_key (
    .resid_i (res_k_in),
    .byte_i  (in_beat_i.in_byte),
    .resid_o (res_k_next)
  );

  lfxd_resid #(
    .MODULUS (POOL_DEPTH),
    .RW      (AW)
  ) u_resid_pool (
    .resid_i (res_p_in),
    .byte_i  (in_beat_i.in_byte),
    .resid_o (res_p_next)
  );

  assign wrap = (phase_q == klast_q);

  always_comb begin
    hb_d        = hb_q;
    shift_d     = shift_q;
    len_d       = len_q;
    remain_d    = remain_q;
    res_k_d     = res_k_q;
    res_p_d     = res_p_q;
    klast_d     = klast_q;
    phase_d     = phase_q;
    start_d     = start_q;
    addr_d      = addr_q;
    emit        = 1'b0;
    emit_status = STATUS_PAYLOAD;
    emit_last   = 1'b0;
    if (is_stream) begin
      priority if (hb_q < HDR_FINAL) begin
        shift_d = {shift_q[15:0], in_beat_i.in_byte};
        res_k_d = res_k_next;
        res_p_d = res_p_next;
        hb_d    = hb_q + HdrCntW'(1);
      end else if (hb_q == HDR_FINAL) begin
        shift_d = '0;
        len_d   = hdr_len;
        if (hdr_len > max_len_q) begin
          hb_d        = HDR_FIRST;
          emit        = 1'b1;
          emit_status = STATUS_TOO_LARGE;
          emit_last   = 1'b1;
        end else if (hdr_len == 32'd0) begin
          hb_d        = HDR_FIRST;
          emit        = 1'b1;
          emit_status = STATUS_EMPTY;
          emit_last   = 1'b1;
        end else begin
          klast_d  = res_k_next;
          phase_d  = '0;
          start_d  = res_p_next;
          addr_d   = res_p_next;
          remain_d = hdr_len;
          hb_d     = HDR_PAYLOAD;
        end
      end else begin
        // payload byte, key byte read from addr_q this cycle
        emit        = 1'b1;
        emit_status = STATUS_PAYLOAD;
        emit_last   = (remain_q == 32'd1);
        remain_d    = remain_q - 32'd1;
        phase_d     = wrap ? '0 : phase_q + KW'(1);
        if (wrap) begin
          addr_d = start_q;
        end else begin
          addr_d = (addr_q == AddrTop) ? '0 : addr_q + AW'(1);
        end
        if (emit_last) begin
          hb_d = HDR_FIRST;
        end
      end
    end
  end

  // pool access: loads write, payload bytes read
  always_comb begin
    pool_req         = '0;
    pool_req.wr_en   = is_load && (9'(in_beat_i.pool_index) < 9'(POOL_DEPTH));
    pool_req.wr_addr = 8'(idx_wide[AW-1:0]);
    pool_req.wr_data = in_beat_i.in_byte;
    pool_req.rd_en   = is_stream && (hb_q == HDR_PAYLOAD);
    pool_req.rd_addr = 8'(addr_q);
  end

  lfxd_pool #(
    .DEPTH (POOL_DEPTH),
    .AW    (AW)
  ) u_pool (
    .clk_i     (clk_i),
    .req_i     (pool_req),
    .rd_data_o (pool_rd)
  );

  // output register fills on a result, drains when not stalled
  always_comb begin
    priority if (in_acc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q        <= HDR_FIRST;
      shift_q     <= '0;
      len_q       <= '0;
      remain_q    <= '0;
      res_k_q     <= '0;
      res_p_q     <= '0;
      klast_q     <= '0;
      phase_q     <= '0;
      start_q     <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      max_len_q   <= MAX_LEN_RESET;
    end else begin
      hb_q        <= hb_d;
      shift_q     <= shift_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      res_k_q     <= res_k_d;
      res_p_q     <= res_p_d;
      klast_q     <= klast_d;
      phase_q     <= phase_d;
      start_q     <= start_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // result payload, loaded with the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      byte_q   <= in_beat_i.in_byte;
      xor_en_q <= (emit_status == STATUS_PAYLOAD);
      status_q <= emit_status;
      last_q   <= emit_last;
      flen_q   <= len_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_beat_o.out_byte     = xor_en_q ? (byte_q ^ pool_rd) : 8'd0;
  assign out_beat_o.status       = status_q;
  assign out_beat_o.last         = last_q;
  assign out_beat_o.frame_length = flen_q;

  // checks
  a_stall_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  a_non_payload_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status != STATUS_PAYLOAD) |-> out_beat_o.last)
    else $error("header result without last");

  a_phase_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= klast_q)
    else $error("key phase beyond key length");

  a_result_on_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_req.rd_en |=> out_valid_o && (out_beat_o.status == STATUS_PAYLOAD))
    else $error("pool read without a payload result");

endmodule

`default_nettype wire
